/* src/tlc_pkg.sv */
`timescale 1ns / 1ps

package tlc_pkg;

  localparam int START_W  = 7;
  localparam int YELLOW_W = 4;
  localparam int BCD_W    = 8;
  localparam int CFG_ADDR_W = 3;

  localparam logic [START_W-1:0]  RED_ONE_RST   = 7'd15;
  localparam logic [START_W-1:0]  GREEN_ONE_RST = 7'd20;
  localparam logic [YELLOW_W-1:0] YELLOW_RST    = 4'd3;
  localparam logic [START_W-1:0]  GREEN_TWO_RST = 7'd12;
  localparam logic [START_W-1:0]  RED_TWO_RST   = 7'd23;

  localparam logic [START_W-1:0]  START_MAX  = 7'd99;
  localparam logic [YELLOW_W-1:0] YELLOW_MAX = 4'd9;
  localparam logic [YELLOW_W-1:0] MANUAL_START = 4'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RED_ONE   = 3'd0,
    CFG_GREEN_ONE = 3'd1,
    CFG_YELLOW    = 3'd2,
    CFG_GREEN_TWO = 3'd3,
    CFG_RED_TWO   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic {
    MAN_Y1R2 = 1'b0,
    MAN_R1Y2 = 1'b1
  } man_phase_t;

  typedef struct packed {
    logic auto_mode;
    logic manual_request;
  } in_item_t;

  typedef struct packed {
    logic             red_one;
    logic             yellow_one;
    logic             green_one;
    logic             red_two;
    logic             yellow_two;
    logic             green_two;
    logic [BCD_W-1:0] display_one;
    logic [BCD_W-1:0] display_two;
  } out_item_t;

  // Binary start value to two BCD digits, saturating at 99.
  function automatic logic [BCD_W-1:0] to_bcd(logic [START_W-1:0] v);
    logic [START_W-1:0] c;
    logic [3:0]         tens;
    logic [START_W-1:0] ones;
    c    = (v > START_MAX) ? START_MAX : v;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (c >= START_W'(i * 10)) tens = tens + 4'd1;
    end
    ones = c - START_W'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [BCD_W-1:0] bcd_dec(logic [BCD_W-1:0] c);
    if (c == '0) begin
      return '0;
    end else if (c[3:0] == 4'd0) begin
      return {c[7:4] - 4'd1, 4'd9};
    end else begin
      return c - 8'd1;
    end
  endfunction

endpackage

/* src/tlc_if.sv */
`timescale 1ns / 1ps

interface tlc_in_if;
  import tlc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlc_out_if;
  import tlc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/two_way_traffic_light_bcd_countdown_unit.sv */
`timescale 1ns / 1ps

// Two-way traffic light sequencer with BCD countdown displays.
// Each word on in_ch is one one-second tick carrying the auto/manual switch
// and the manual request. Every tick produces exactly one word on out_ch:
// six lamps and two 2-digit BCD displays (tens in the high nibble).
// Phase starts are written via cfg_we/cfg_addr/cfg_wdata; writes to an unused
// index are ignored. The user must write them only while the block is idle;
// the block does not enforce this. A tick accepted at a clock edge has its
// result valid in the output register right after that edge. Throughput is
// one tick per clock unless the receiver stalls; the whole next-state and
// lamp decode is one combinational stage in front of the result register.
// The output register doubles as the record of the last result, which the
// manual mode repeats when no request is present.
// When the receiver stalls, the result holds and in_ch.ready falls until the
// word is taken; ready is high again in the same cycle the word leaves.
// Synchronous reset restores the start values 15, 20, 3, 12 and 23, puts
// approach one in red and approach two in green, and clears the outputs.
module two_way_traffic_light_bcd_countdown_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tlc_in_if.sink                         in_ch,
  tlc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlc_pkg::START_W-1:0]    cfg_wdata
);
  import tlc_pkg::*;

  logic [START_W-1:0]  red_one_r, green_one_r, green_two_r, red_two_r;
  logic [YELLOW_W-1:0] yellow_r;

  phase_t             phase_one_r, phase_one_nxt;
  phase_t             phase_two_r, phase_two_nxt;
  logic [BCD_W-1:0]   count_one_r, count_one_nxt;
  logic [BCD_W-1:0]   count_two_r, count_two_nxt;
  man_phase_t         man_phase_r, man_phase_nxt;
  logic [YELLOW_W-1:0] man_count_r, man_count_nxt;
  logic               man_started_r, man_started_nxt;

  logic      out_valid_r;
  out_item_t out_data_r, res_nxt;
  logic      in_acc;
  logic [BCD_W-1:0] yellow_bcd;
  man_phase_t          mp;
  logic [YELLOW_W-1:0] mc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign yellow_bcd = {4'd0, (yellow_r > YELLOW_MAX) ? YELLOW_MAX : yellow_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_one_r   <= RED_ONE_RST;
      green_one_r <= GREEN_ONE_RST;
      yellow_r    <= YELLOW_RST;
      green_two_r <= GREEN_TWO_RST;
      red_two_r   <= RED_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RED_ONE:   red_one_r   <= cfg_wdata;
        CFG_GREEN_ONE: green_one_r <= cfg_wdata;
        CFG_YELLOW:    yellow_r    <= cfg_wdata[YELLOW_W-1:0];
        CFG_GREEN_TWO: green_two_r <= cfg_wdata;
        CFG_RED_TWO:   red_two_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_one_nxt   = phase_one_r;
    phase_two_nxt   = phase_two_r;
    count_one_nxt   = count_one_r;
    count_two_nxt   = count_two_r;
    man_phase_nxt   = man_phase_r;
    man_count_nxt   = man_count_r;
    man_started_nxt = man_started_r;
    res_nxt         = '0;
    mp              = man_phase_r;
    mc              = man_count_r;

    if (phase_two_r == PH_DONE) begin
      // Blank tick: lamps stay, displays go to zero, the cycle restarts.
      res_nxt.red_one    = out_data_r.red_one;
      res_nxt.yellow_one = out_data_r.yellow_one;
      res_nxt.green_one  = out_data_r.green_one;
      res_nxt.red_two    = out_data_r.red_two;
      res_nxt.yellow_two = out_data_r.yellow_two;
      res_nxt.green_two  = out_data_r.green_two;
      man_started_nxt    = 1'b0;
      phase_one_nxt      = PH_RED;
      count_one_nxt      = to_bcd(red_one_r);
      if (green_two_r == '0) begin
        phase_two_nxt = PH_YELLOW;
        count_two_nxt = yellow_bcd;
      end else begin
        phase_two_nxt = PH_GREEN;
        count_two_nxt = to_bcd(green_two_r);
      end
    end else if (in_ch.data.auto_mode) begin
      man_started_nxt = 1'b0;
      unique case (phase_one_r)
        PH_RED: begin
          res_nxt.red_one     = 1'b1;
          res_nxt.display_one = count_one_r;
          if (count_one_r == '0) begin
            if (green_one_r == '0) begin
              phase_one_nxt = PH_YELLOW;
              count_one_nxt = yellow_bcd;
            end else begin
              phase_one_nxt = PH_GREEN;
              count_one_nxt = to_bcd(green_one_r);
            end
          end else begin
            count_one_nxt = bcd_dec(count_one_r);
          end
        end
        PH_GREEN: begin
          res_nxt.green_one   = 1'b1;
          res_nxt.display_one = count_one_r;
          if (count_one_r <= 8'd1) begin
            phase_one_nxt = PH_YELLOW;
            count_one_nxt = yellow_bcd;
          end else begin
            count_one_nxt = bcd_dec(count_one_r);
          end
        end
        PH_YELLOW: begin
          res_nxt.yellow_one  = 1'b1;
          res_nxt.display_one = count_one_r;
          if (count_one_r == '0) begin
            phase_one_nxt = PH_DONE;
          end else begin
            count_one_nxt = bcd_dec(count_one_r);
          end
        end
        default: ;
      endcase
      unique case (phase_two_r)
        PH_GREEN: begin
          res_nxt.green_two   = 1'b1;
          res_nxt.display_two = count_two_r;
          if (count_two_r <= 8'd1) begin
            phase_two_nxt = PH_YELLOW;
            count_two_nxt = yellow_bcd;
          end else begin
            count_two_nxt = bcd_dec(count_two_r);
          end
        end
        PH_YELLOW: begin
          res_nxt.yellow_two  = 1'b1;
          res_nxt.display_two = count_two_r;
          if (count_two_r == '0) begin
            if (red_two_r == '0) begin
              phase_two_nxt = PH_DONE;
              count_two_nxt = '0;
            end else begin
              phase_two_nxt = PH_RED;
              count_two_nxt = to_bcd(red_two_r);
            end
          end else begin
            count_two_nxt = bcd_dec(count_two_r);
          end
        end
        default: begin
          res_nxt.red_two     = 1'b1;
          res_nxt.display_two = count_two_r;
          if (count_two_r <= 8'd1) begin
            phase_two_nxt = PH_DONE;
            count_two_nxt = '0;
          end else begin
            count_two_nxt = bcd_dec(count_two_r);
          end
        end
      endcase
    end else begin
      // Manual mode; the first manual tick starts from a clean slate.
      man_started_nxt = 1'b1;
      if (!man_started_r) begin
        mp = MAN_Y1R2;
        mc = MANUAL_START;
      end
      if (in_ch.data.manual_request) begin
        if (mp == MAN_Y1R2) begin
          res_nxt.yellow_one = 1'b1;
          res_nxt.red_two    = 1'b1;
        end else begin
          res_nxt.red_one    = 1'b1;
          res_nxt.yellow_two = 1'b1;
        end
        res_nxt.display_one = {4'd0, mc};
        res_nxt.display_two = {4'd0, mc};
        if (mc == '0) begin
          man_phase_nxt = (mp == MAN_Y1R2) ? MAN_R1Y2 : MAN_Y1R2;
          man_count_nxt = MANUAL_START;
        end else begin
          man_phase_nxt = mp;
          man_count_nxt = mc - 4'd1;
        end
      end else begin
        man_phase_nxt = mp;
        man_count_nxt = mc;
        res_nxt       = man_started_r ? out_data_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_one_r   <= PH_RED;
      phase_two_r   <= PH_GREEN;
      count_one_r   <= to_bcd(RED_ONE_RST);
      count_two_r   <= to_bcd(GREEN_TWO_RST);
      man_phase_r   <= MAN_Y1R2;
      man_count_r   <= MANUAL_START;
      man_started_r <= 1'b0;
      out_data_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_one_r   <= phase_one_nxt;
        phase_two_r   <= phase_two_nxt;
        count_one_r   <= count_one_nxt;
        count_two_r   <= count_two_nxt;
        man_phase_r   <= man_phase_nxt;
        man_count_r   <= man_count_nxt;
        man_started_r <= man_started_nxt;
        out_data_r    <= res_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_blank_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_two_r == PH_DONE |=>
      out_data_r.display_one == '0 && out_data_r.display_two == '0 &&
      phase_one_r == PH_RED)
    else $error("blank tick did not clear displays or restart the cycle");

  a_manual_entry_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.data.auto_mode && !in_ch.data.manual_request &&
    !man_started_r && phase_two_r != PH_DONE |=> out_data_r == '0)
    else $error("entering manual mode without request must show all off");

  a_one_lamp_each: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      $onehot0({out_data_r.red_one, out_data_r.yellow_one, out_data_r.green_one}) &&
      $onehot0({out_data_r.red_two, out_data_r.yellow_two, out_data_r.green_two}))
    else $error("more than one lamp lit on an approach");

  a_approach_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.data.auto_mode && phase_two_r != PH_DONE &&
    phase_one_r == PH_DONE |=>
      out_data_r.display_one == '0 && !out_data_r.red_one &&
      !out_data_r.yellow_one && !out_data_r.green_one)
    else $error("finished approach one must stay dark");

endmodule
